FILE: design/kci_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyframe curve interpolator.
// No dependencies; imported by kci_weight, keyframe_curve_interpolator_top and the bench.
package kci_pkg;

  localparam int unsigned T_BITS      = 16;
  localparam int unsigned WEIGHT_BITS = 28;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned WGT_W       = 30;
  localparam int unsigned PROD_W      = VAL_W + WGT_W;
  localparam int unsigned SUM_W       = 64;

  localparam logic [16:0] T_ONE       = 17'h10000;
  localparam logic [17:0] T_ONE_X1    = 18'h10000;
  localparam logic [17:0] T_ONE_X3    = 18'h30000;
  localparam logic [51:0] WGT_ROUND   = 52'h80000;
  localparam logic signed [SUM_W-1:0] SUM_ROUND = 64'sh8000000;

  typedef enum logic [1:0] {
    FUNC_HOLD    = 2'd0,
    FUNC_LINEAR  = 2'd1,
    FUNC_BEZIER  = 2'd2,
    FUNC_HERMITE = 2'd3
  } func_e;

  typedef struct packed {
    func_e func;
    logic  whole;
  } ctrl_t;

  typedef logic signed [WGT_W-1:0] weight_t;

endpackage

FILE: design/kci_weight.sv
`timescale 1ns / 1ps
// Three-stage basis weight generator: squares, cubic terms, signed Q1.28 rounding.
// Depends on kci_pkg; stage enables come from the top-level pipeline control.
module kci_weight import kci_pkg::*; (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  logic [16:0]         t_i,
  input  logic [16:0]         u_i,
  input  func_e               func_i,
  output weight_t [3:0]       w_o
);

  function automatic logic [28:0] round48(input logic [51:0] x);
    logic [51:0] s;
    s = x + WGT_ROUND;
    return s[48:20];
  endfunction

  // stage B
  logic [32:0] uu_q, tt_q;
  logic [17:0] k0_q, k3_q;
  logic [16:0] tb_q, ub_q;
  func_e       funcb_q;

  // stage C
  logic [50:0] m0_q, m1_q, m2_q, m3_q;
  logic [16:0] tc_q, uc_q;
  func_e       funcc_q;

  // stage D
  weight_t [3:0] w_q;
  weight_t [3:0] w_d;

  logic [17:0] k0_d, k3_d;
  logic [51:0] m1x3, m2x3;

  always_comb begin
    if (func_i == FUNC_BEZIER) begin
      k0_d = {1'b0, u_i};
      k3_d = {1'b0, t_i};
    end else begin
      k0_d = T_ONE_X1 + {t_i, 1'b0};
      k3_d = T_ONE_X3 - {t_i, 1'b0};
    end
  end

  assign m1x3 = {m1_q, 1'b0} + {1'b0, m1_q};
  assign m2x3 = {m2_q, 1'b0} + {1'b0, m2_q};

  always_comb begin
    w_d = '0;
    case (funcc_q)
      FUNC_LINEAR: begin
        w_d[0] = WGT_W'(uc_q) <<< (WEIGHT_BITS - T_BITS);
        w_d[3] = WGT_W'(tc_q) <<< (WEIGHT_BITS - T_BITS);
      end
      FUNC_BEZIER: begin
        w_d[0] = WGT_W'(round48({1'b0, m0_q}));
        w_d[1] = WGT_W'(round48(m1x3));
        w_d[2] = WGT_W'(round48(m2x3));
        w_d[3] = WGT_W'(round48({1'b0, m3_q}));
      end
      FUNC_HERMITE: begin
        w_d[0] = WGT_W'(round48({1'b0, m0_q}));
        w_d[1] = WGT_W'(round48({1'b0, m1_q}));
        w_d[2] = -WGT_W'(round48({1'b0, m2_q}));
        w_d[3] = WGT_W'(round48({1'b0, m3_q}));
      end
      default: w_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      uu_q    <= 33'(u_i) * 33'(u_i);
      tt_q    <= 33'(t_i) * 33'(t_i);
      k0_q    <= k0_d;
      k3_q    <= k3_d;
      tb_q    <= t_i;
      ub_q    <= u_i;
      funcb_q <= func_i;
    end
    if (en_i[1]) begin
      m0_q    <= 51'(uu_q) * 51'(k0_q);
      m1_q    <= 51'(uu_q) * 51'(tb_q);
      m2_q    <= 51'(tt_q) * 51'(ub_q);
      m3_q    <= 51'(tt_q) * 51'(k3_q);
      tc_q    <= tb_q;
      uc_q    <= ub_q;
      funcc_q <= funcb_q;
    end
    if (en_i[2]) begin
      w_q <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

FILE: design/keyframe_curve_interpolator_top.sv
`timescale 1ns / 1ps
// Keyframe curve interpolator: hold, linear, cubic Bezier and Hermite segments.
// Nine register stages; a result leaves from the last of them, value_q.
// Throughput one item per cycle while the output accepts; a full stage
// stalls only when the stage after it stalls, so bubbles collapse. Reset
// clears the stage valid bits only. Depends on kci_pkg and kci_weight.
module keyframe_curve_interpolator_top import kci_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // left_value[31:0], left_out_tangent[63:32], right_in_tangent[95:64],
  // right_value[127:96], position[144:128], zero pad[151:145]
  input  logic [151:0] s_axis_tdata_i,
  // func[1:0], whole_number[2]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // value[31:0]
  output logic [31:0]  m_axis_tdata_o
);

  localparam int unsigned NSTG = 9;
  localparam logic [31:0] KEEP_MASK =
    {{(32 - FRACTION_BITS){1'b1}}, {FRACTION_BITS{1'b0}}};

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  logic signed [VAL_W-1:0]  vals_q [4][4];
  logic [16:0]              t0_q, u0_q;
  ctrl_t                    ctrl_q [8];
  weight_t [3:0]            w;
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [VAL_W-1:0]  hold_q [3];
  logic signed [SUM_W-1:0]  s01_q, s23_q, total_q;
  logic signed [VAL_W-1:0]  sat_q, value_q;

  logic [16:0]              pos, t_d;
  logic signed [35:0]       r36;
  logic signed [VAL_W-1:0]  sat_d, value_d;
  logic [32:0]              mag;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // clamp position to one
  assign pos = s_axis_tdata_i[144:128];
  assign t_d = (pos > T_ONE) ? T_ONE : pos;

  kci_weight u_weight (
    .clk_i  (clk_i),
    .en_i   (en[3:1]),
    .t_i    (t0_q),
    .u_i    (u0_q),
    .func_i (ctrl_q[0].func),
    .w_o    (w)
  );

  assign r36 = total_q[63:28];

  always_comb begin
    if (ctrl_q[6].func == FUNC_HOLD) begin
      sat_d = hold_q[2];
    end else if ((&r36[35:31]) || !(|r36[35:31])) begin
      sat_d = r36[31:0];
    end else if (r36[35]) begin
      sat_d = 32'sh8000_0000;
    end else begin
      sat_d = 32'sh7fff_ffff;
    end
  end

  // truncate toward zero on integer tracks
  assign mag = -{sat_q[31], sat_q};
  always_comb begin
    if (!ctrl_q[7].whole) begin
      value_d = sat_q;
    end else if (!sat_q[31]) begin
      value_d = sat_q & KEEP_MASK;
    end else begin
      value_d = 32'(-(mag & {1'b1, KEEP_MASK}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vals_q[0][0] <= s_axis_tdata_i[31:0];
      vals_q[0][1] <= s_axis_tdata_i[63:32];
      vals_q[0][2] <= s_axis_tdata_i[95:64];
      vals_q[0][3] <= s_axis_tdata_i[127:96];
      t0_q         <= t_d;
      u0_q         <= T_ONE - t_d;
      ctrl_q[0]    <= '{func: func_e'(s_axis_tuser_i[1:0]), whole: s_axis_tuser_i[2]};
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        vals_q[k] <= vals_q[k-1];
      end
    end
    for (int k = 1; k < 8; k++) begin
      if (en[k]) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= PROD_W'(vals_q[3][i]) * PROD_W'(w[i]);
      end
      hold_q[0] <= vals_q[3][0];
    end
    if (en[5]) begin
      s01_q     <= SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]);
      s23_q     <= SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
      hold_q[1] <= hold_q[0];
    end
    if (en[6]) begin
      total_q   <= s01_q + s23_q + SUM_ROUND;
      hold_q[2] <= hold_q[1];
    end
    if (en[7]) begin
      sat_q <= sat_d;
    end
    if (en[8]) begin
      value_q <= value_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NSTG-1];
  assign m_axis_tdata_o  = value_q;

  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output side is ready");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output stage");

  a_first_stage_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted item missing from first stage");

endmodule

FILE: tb/tb_keyframe_curve_interpolator_top.sv
`timescale 1ns / 1ps
// Self-checking bench for keyframe_curve_interpolator_top: a table of directed items, then
// random items under random gaps, stalls and one long output hold-off. Results are matched
// in order against a bit-exact predictor. Depends on kci_pkg and the design sources.
module tb_keyframe_curve_interpolator_top;
  import kci_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int RANDOM_ITEMS    = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam longint unsigned ONE = 64'd65536;
  localparam longint FRAC_MASK   = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] v3;
    logic [16:0] pos;
    func_e       func;
    logic        whole;
  } curve_item_t;

  typedef struct packed {
    curve_item_t item;
    logic        known;
    logic [31:0] value;
  } table_row_t;

  logic         clk_i;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_axis_tready_o;
  // left_value[31:0], left_out_tangent[63:32], right_in_tangent[95:64],
  // right_value[127:96], position[144:128], zero pad[151:145]
  logic [151:0] s_tdata  = '0;
  // func[1:0], whole_number[2]
  logic [2:0]   s_tuser  = '0;
  logic         m_axis_tvalid_o;
  logic         m_tready = 1'b0;
  // value[31:0]
  logic [31:0]  m_axis_tdata_o;

  logic [31:0] expected_values[$];
  int          errors       = 0;
  logic        burst        = 1'b0;
  logic        hold_off_req = 1'b0;

  table_row_t dir_tab [25] = '{
    '{'{32'h7FFF_FFFF, 32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 17'h08000,
        FUNC_HOLD, 1'b0}, 1'b1, 32'h7FFF_FFFF},
    '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF,
        FUNC_HOLD, 1'b0}, 1'b1, 32'h8000_0000},
    '{'{32'hFFFE_8000, 32'h0, 32'h0, 32'h0, 17'h00000,
        FUNC_HOLD, 1'b1}, 1'b1, 32'hFFFF_0000},
    '{'{32'h0001_FFFF, 32'h0, 32'h0, 32'h0, 17'h10000,
        FUNC_HOLD, 1'b1}, 1'b1, 32'h0001_0000},
    '{'{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 17'h04000,
        FUNC_HOLD, 1'b1}, 1'b1, 32'h7FFF_0000},
    '{'{32'h8000_0000, 32'h0, 32'h0, 32'h0, 17'h04000,
        FUNC_HOLD, 1'b1}, 1'b1, 32'h8000_0000},
    '{'{32'h0001_2345, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, 17'h00000,
        FUNC_LINEAR, 1'b0}, 1'b1, 32'h0001_2345},
    '{'{32'h0001_2345, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, 17'h10000,
        FUNC_LINEAR, 1'b0}, 1'b1, 32'hFFFF_0000},
    '{'{32'h0004_0000, 32'h0, 32'h0, 32'h0030_0000, 17'h1FFFF,
        FUNC_LINEAR, 1'b0}, 1'b1, 32'h0030_0000},
    '{'{32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 17'h10001,
        FUNC_LINEAR, 1'b0}, 1'b1, 32'h7FFF_FFFF},
    '{'{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 17'h08000,
        FUNC_LINEAR, 1'b0}, 1'b1, 32'h7FFF_FFFF},
    '{'{32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 17'h08000,
        FUNC_LINEAR, 1'b0}, 1'b1, 32'h8000_0000},
    '{'{32'hFFF3_1000, 32'h0, 32'h0, 32'h0012_0ABC, 17'h04000,
        FUNC_LINEAR, 1'b0}, 1'b0, 32'h0},
    '{'{32'h1111_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h2222_0000, 17'h00000,
        FUNC_BEZIER, 1'b0}, 1'b1, 32'h1111_0000},
    '{'{32'h1111_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hDEAD_0000, 17'h10000,
        FUNC_BEZIER, 1'b0}, 1'b1, 32'hDEAD_0000},
    '{'{32'h0010_0000, 32'hFFE0_0000, 32'h0030_8000, 32'hFFFF_C000, 17'h08000,
        FUNC_BEZIER, 1'b0}, 1'b0, 32'h0},
    '{'{32'h1234_0000, 32'h0, 32'h0, 32'h0005_0000, 17'h1FFFF,
        FUNC_BEZIER, 1'b0}, 1'b1, 32'h0005_0000},
    '{'{32'h0ABC_DEF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 17'h00000,
        FUNC_HERMITE, 1'b0}, 1'b1, 32'h0ABC_DEF0},
    '{'{32'h0ABC_DEF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 17'h10000,
        FUNC_HERMITE, 1'b0}, 1'b1, 32'h8000_0000},
    '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 17'h08000,
        FUNC_HERMITE, 1'b0}, 1'b1, 32'h7FFF_FFFF},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 17'h08000,
        FUNC_HERMITE, 1'b0}, 1'b1, 32'h8000_0000},
    '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 17'h08000,
        FUNC_HERMITE, 1'b1}, 1'b1, 32'h7FFF_0000},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 17'h08000,
        FUNC_HERMITE, 1'b1}, 1'b1, 32'h8000_0000},
    '{'{32'hFFF8_4321, 32'h0003_0000, 32'hFFFA_0000, 32'h0002_8000, 17'h05555,
        FUNC_HERMITE, 1'b1}, 1'b0, 32'h0},
    '{'{32'hFFFE_0001, 32'hFFF0_0000, 32'h0011_0000, 32'hFFFF_7FFF, 17'h0AAAA,
        FUNC_BEZIER, 1'b1}, 1'b0, 32'h0}
  };

  keyframe_curve_interpolator_top #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint q48_to_q28(longint unsigned w);
    return longint'((w + 64'd524288) >> 20);
  endfunction

  function automatic logic [31:0] curve_value(curve_item_t it);
    longint unsigned t;
    longint unsigned u;
    longint w0, w1, w2, w3, acc, r;
    t  = (it.pos > T_ONE) ? ONE : longint'(it.pos);
    u  = ONE - t;
    w0 = 0;
    w1 = 0;
    w2 = 0;
    w3 = 0;
    case (it.func)
      FUNC_LINEAR: begin
        w0 = longint'(u << 12);
        w3 = longint'(t << 12);
      end
      FUNC_BEZIER: begin
        w0 = q48_to_q28(u * u * u);
        w1 = q48_to_q28(3 * t * u * u);
        w2 = q48_to_q28(3 * t * t * u);
        w3 = q48_to_q28(t * t * t);
      end
      FUNC_HERMITE: begin
        w0 = q48_to_q28(u * u * (ONE + 2 * t));
        w1 = q48_to_q28(t * u * u);
        w2 = -q48_to_q28(t * t * u);
        w3 = q48_to_q28(t * t * (3 * ONE - 2 * t));
      end
      default: ;
    endcase
    if (it.func == FUNC_HOLD) begin
      r = longint'($signed(it.v0));
    end else begin
      acc = longint'($signed(it.v0)) * w0 + longint'($signed(it.v1)) * w1
          + longint'($signed(it.v2)) * w2 + longint'($signed(it.v3)) * w3;
      r = (acc + 64'sd134217728) >>> 28;
      if (r > VAL_MAX) r = VAL_MAX;
      if (r < VAL_MIN) r = VAL_MIN;
    end
    if (it.whole) begin
      if (r >= 0) r = r & ~FRAC_MASK;
      else r = -((-r) & ~FRAC_MASK);
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      3, 4:    return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input curve_item_t it, input logic known,
                           input logic [31:0] typed, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.pos, it.v3, it.v2, it.v1, it.v0};
    s_tuser  <= {it.whole, it.func};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_values.push_back(known ? typed : curve_value(it));
  endtask

  initial begin : stimulus
    curve_item_t it;
    int          gap;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].item, dir_tab[k].known, dir_tab[k].value, $urandom_range(0, 9));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = (i >= 100 && i < 160);
      if (i == 220) hold_off_req = 1'b1;
      it.v0    = rand_value();
      it.v1    = rand_value();
      it.v2    = rand_value();
      it.v3    = rand_value();
      case ($urandom_range(0, 9))
        0:       it.pos = 17'd0;
        1:       it.pos = T_ONE;
        2:       it.pos = 17'($urandom_range(65537, 131071));
        default: it.pos = 17'($urandom_range(0, 65536));
      endcase
      it.func  = func_e'(2'($urandom_range(0, 3)));
      it.whole = 1'($urandom_range(0, 1));
      gap = (burst || (i >= 220 && i < 280)) ? 0 : $urandom_range(0, 9);
      send_item(it, 1'b0, 32'h0, gap);
    end
    burst = 1'b0;
    s_tvalid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int wait_cycles;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      wait_cycles = burst ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result: value actual %h", m_axis_tdata_o);
        errors++;
      end else begin
        if (m_axis_tdata_o !== expected_values[0]) begin
          $error("value mismatch: expected %h, actual %h", expected_values[0],
                 m_axis_tdata_o);
          errors++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  initial begin : limit
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
